>>> sv/vdh_pkg.sv
`timescale 1ns / 1ps

package vdh_pkg;

	// Default sizing of the histogram.
	localparam int MAX_BINS_DEF   = 128;
	localparam int COUNT_BITS_DEF = 32;

	// Configuration port.
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 2;

	localparam logic [REG_IDX_W-1:0] REG_LEFT_EDGE   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BIN_SCALE   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_BINS_IN_USE = 2'd2;

	// Register reset values.
	localparam logic signed [15:0] LEFT_EDGE_RST   = -16'sd1638;
	localparam logic        [15:0] BIN_SCALE_RST   = 16'd25600;
	localparam logic        [7:0]  BINS_IN_USE_RST = 8'd81;

	// Reset values of the running extremes.
	localparam logic signed [15:0] VEL_MOST_POS = 16'sh7FFF;
	localparam logic signed [15:0] VEL_MOST_NEG = 16'sh8000;

	// Width used to compare bin indices against the grid size.
	localparam int IDX_CMP_W = 16;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_READ = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t            opcode;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic        [6:0]  query_x;
		logic        [6:0]  query_y;
	} in_item_t;

	typedef struct packed {
		logic               in_grid;
		logic        [31:0] bin_count;
		logic        [31:0] points_seen;
		logic        [31:0] hits_total;
		logic signed [15:0] min_x;
		logic signed [15:0] max_x;
		logic signed [15:0] min_y;
		logic signed [15:0] max_y;
	} out_item_t;

	typedef struct packed {
		logic signed [15:0] left_edge;
		logic        [15:0] bin_scale;
		logic        [7:0]  bins_in_use;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic accept;
		logic issue;
		logic commit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
	} ctrl_sts_t;

endpackage

>>> sv/velocity_2d_histogram.sv
`timescale 1ns / 1ps
// An item loads the item registers, then the address stage and bin RAM read, then
// commits the RAM write and result; a new item may enter as the last one commits.
// A waiting result stalls the next update until it is taken.
// Reset: asynchronous; afterward a clearing pass writes zero to all MAX_BINS*MAX_BINS
// bins (16384 by default), one a cycle, with in_ready low; writes still work.

module velocity_2d_histogram
	import vdh_pkg::*;
#(
	parameter int MAX_BINS   = MAX_BINS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data
);

	cfg_t      cfg;
	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	vdh_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vdh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	vdh_datapath #(
		.MAX_BINS   (MAX_BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_data  (in_data),
		.out_data (out_data),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

>>> sv/vdh_ram.sv
`timescale 1ns / 1ps

module vdh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/vdh_regs.sv
`timescale 1ns / 1ps

module vdh_regs
	import vdh_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	cfg_t                 cfg_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	// Register writes; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_edge   <= LEFT_EDGE_RST;
			cfg_q.bin_scale   <= BIN_SCALE_RST;
			cfg_q.bins_in_use <= BINS_IN_USE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_LEFT_EDGE:   cfg_q.left_edge   <= pwdata[15:0];
				REG_BIN_SCALE:   cfg_q.bin_scale   <= pwdata[15:0];
				REG_BINS_IN_USE: cfg_q.bins_in_use <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back; an unknown index reads as zero.
	always_comb begin
		case (reg_idx)
			REG_LEFT_EDGE:   prdata = APB_DATA_W'($unsigned(cfg_q.left_edge));
			REG_BIN_SCALE:   prdata = APB_DATA_W'(cfg_q.bin_scale);
			REG_BINS_IN_USE: prdata = APB_DATA_W'(cfg_q.bins_in_use);
			default:         prdata = '0;
		endcase
	end

endmodule

>>> sv/vdh_ctrl.sv
`timescale 1ns / 1ps

module vdh_ctrl
	import vdh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output ctrl_cmd_t cmd,
	input  ctrl_sts_t sts
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADDR,
		ST_UPD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;
	logic   commit;

	// The result register is free when empty or being emptied this cycle.
	assign out_free = !out_valid_q || out_ready;

	// A new item may enter while the previous one commits its bin update.
	assign in_ready = (state_q == ST_IDLE) || ((state_q == ST_UPD) && out_free);
	assign accept   = in_valid && in_ready;
	assign commit   = (state_q == ST_UPD) && out_free;

	assign cmd.clear  = (state_q == ST_CLEAR);
	assign cmd.accept = accept;
	assign cmd.issue  = (state_q == ST_ADDR);
	assign cmd.commit = commit;

	assign out_valid = out_valid_q;

	// State and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (sts.clear_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (commit) begin
						state_q <= accept ? ST_ADDR : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sv/vdh_datapath.sv
`timescale 1ns / 1ps

module vdh_datapath
	import vdh_pkg::*;
#(
	parameter int MAX_BINS   = MAX_BINS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  in_item_t  in_data,
	output out_item_t out_data,
	input  ctrl_cmd_t cmd,
	output ctrl_sts_t sts
);

	localparam int DEPTH  = MAX_BINS * MAX_BINS;
	localparam int ADDR_W = $clog2(DEPTH);

	// Saturated counter shown in a 32 bit field.
	function automatic logic [31:0] show(input logic [COUNT_BITS-1:0] c);
		logic [COUNT_BITS-1:0] hi;
		hi = c >> 32;
		if (hi != '0) begin
			return '1;
		end
		return 32'(c);
	endfunction

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	// Offsets from the left edge and their scaled products.
	logic signed [16:0] off_x;
	logic signed [16:0] off_y;
	logic signed [33:0] prod_x;
	logic signed [33:0] prod_y;

	assign off_x  = {in_data.vel_x[15], in_data.vel_x} - {cfg.left_edge[15], cfg.left_edge};
	assign off_y  = {in_data.vel_y[15], in_data.vel_y} - {cfg.left_edge[15], cfg.left_edge};
	assign prod_x = off_x * $signed({1'b0, cfg.bin_scale});
	assign prod_y = off_y * $signed({1'b0, cfg.bin_scale});

	// Item registers, loaded when an item is accepted.
	opcode_t            op_q;
	logic        [6:0]  qx_q;
	logic        [6:0]  qy_q;
	logic signed [33:0] prod_x_s1;
	logic signed [33:0] prod_y_s1;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q      <= in_data.opcode;
			qx_q      <= in_data.query_x;
			qy_q      <= in_data.query_y;
			prod_x_s1 <= prod_x;
			prod_y_s1 <= prod_y;
		end
	end

	// Running statistics of the samples.
	logic [COUNT_BITS-1:0] samples_q;
	logic [COUNT_BITS-1:0] hits_q;
	logic [COUNT_BITS-1:0] hits_next;
	logic signed [15:0]    low_x_q;
	logic signed [15:0]    high_x_q;
	logic signed [15:0]    low_y_q;
	logic signed [15:0]    high_y_q;
	logic                  sample_in;

	assign sample_in = cmd.accept && (in_data.opcode == OP_ADD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_q <= '0;
			hits_q    <= '0;
			low_x_q   <= VEL_MOST_POS;
			high_x_q  <= VEL_MOST_NEG;
			low_y_q   <= VEL_MOST_POS;
			high_y_q  <= VEL_MOST_NEG;
		end else begin
			if (sample_in) begin
				samples_q <= sat_inc(samples_q);
				if (in_data.vel_x < low_x_q) begin
					low_x_q <= in_data.vel_x;
				end
				if (in_data.vel_x > high_x_q) begin
					high_x_q <= in_data.vel_x;
				end
				if (in_data.vel_y < low_y_q) begin
					low_y_q <= in_data.vel_y;
				end
				if (in_data.vel_y > high_y_q) begin
					high_y_q <= in_data.vel_y;
				end
			end
			if (cmd.commit) begin
				hits_q <= hits_next;
			end
		end
	end

	// Bin indices, grid test and bin address.
	logic [IDX_CMP_W-1:0] grid_n;
	logic [IDX_CMP_W-1:0] bin_x;
	logic [IDX_CMP_W-1:0] bin_y;
	logic [IDX_CMP_W-1:0] idx_x;
	logic [IDX_CMP_W-1:0] idx_y;
	logic                 hit_x;
	logic                 hit_y;
	logic                 in_grid;
	logic [ADDR_W-1:0]    addr;

	assign grid_n = (IDX_CMP_W'(cfg.bins_in_use) < IDX_CMP_W'(MAX_BINS)) ?
		IDX_CMP_W'(cfg.bins_in_use) : IDX_CMP_W'(MAX_BINS);
	assign bin_x  = IDX_CMP_W'(prod_x_s1[32:20]);
	assign bin_y  = IDX_CMP_W'(prod_y_s1[32:20]);
	assign hit_x  = !prod_x_s1[33] && (bin_x < grid_n);
	assign hit_y  = !prod_y_s1[33] && (bin_y < grid_n);

	always_comb begin
		if (op_q == OP_READ) begin
			idx_x   = IDX_CMP_W'(qx_q);
			idx_y   = IDX_CMP_W'(qy_q);
			in_grid = (IDX_CMP_W'(qx_q) < grid_n) && (IDX_CMP_W'(qy_q) < grid_n);
		end else begin
			idx_x   = bin_x;
			idx_y   = bin_y;
			in_grid = hit_x && hit_y;
		end
		if (in_grid) begin
			addr = ADDR_W'(ADDR_W'(idx_x) * ADDR_W'(MAX_BINS) + ADDR_W'(idx_y));
		end else begin
			addr = '0;
		end
	end

	// Address stage results held for the update.
	logic [ADDR_W-1:0] addr_s2;
	logic              in_grid_s2;

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			addr_s2    <= addr;
			in_grid_s2 <= in_grid;
		end
	end

	// Clearing sweep over the bin store after reset.
	logic [ADDR_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign sts.clear_last = (clr_addr_q == ADDR_W'(DEPTH - 1));

	// Bin store and its read-modify-write.
	logic [COUNT_BITS-1:0] rdata;
	logic [COUNT_BITS-1:0] bin_inc;
	logic                  bin_we;
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;

	assign bin_inc   = sat_inc(rdata);
	assign bin_we    = cmd.commit && (op_q == OP_ADD) && in_grid_s2;
	assign hits_next = bin_we ? sat_inc(hits_q) : hits_q;
	assign ram_we    = cmd.clear || bin_we;
	assign ram_waddr = cmd.clear ? clr_addr_q : addr_s2;
	assign ram_wdata = cmd.clear ? '0 : bin_inc;

	vdh_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (DEPTH)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.issue),
		.raddr (addr),
		.rdata (rdata)
	);

	// Result register, loaded when the item commits.
	out_item_t out_q;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.in_grid     <= in_grid_s2;
			if (!in_grid_s2) begin
				out_q.bin_count <= '0;
			end else if (op_q == OP_READ) begin
				out_q.bin_count <= show(rdata);
			end else begin
				out_q.bin_count <= show(bin_inc);
			end
			out_q.points_seen <= show(samples_q);
			out_q.hits_total  <= show(hits_next);
			out_q.min_x       <= low_x_q;
			out_q.max_x       <= high_x_q;
			out_q.min_y       <= low_y_q;
			out_q.max_y       <= high_y_q;
		end
	end

	assign out_data = out_q;

endmodule
